// ===== rtl/handle_table_free_list_macros.svh =====
// Assertion macros for the handle table with free list.
`ifndef HANDLE_TABLE_FREE_LIST_MACROS_SVH
`define HANDLE_TABLE_FREE_LIST_MACROS_SVH

// Same-cycle implication, clocked on clk, off while arst_n is low.
`define HTFL_ASSERT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> cons) \
		else $error(msg);

// Next-cycle implication, clocked on clk, off while arst_n is low.
`define HTFL_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> cons) \
		else $error(msg);

`endif

// ===== rtl/htfl_pkg.sv =====
// Types, codes and constants shared by the handle table files.
package htfl_pkg;

	// Parameter defaults
	localparam int TABLE_DEPTH_DEF = 1024;
	localparam int GROW_CHUNK_DEF  = 64;
	localparam int TAG_WIDTH_DEF   = 32;

	// Fixed field widths
	localparam int CMD_W    = 2;
	localparam int HANDLE_W = 32;
	localparam int TAG_W    = 32;
	localparam int STATUS_W = 2;

	// Handle values that never name a slot
	localparam logic [HANDLE_W-1:0] HANDLE_NULL     = 32'h0000_0000;
	localparam logic [HANDLE_W-1:0] HANDLE_ALL_ONES = 32'hFFFF_FFFF;
	localparam logic [HANDLE_W-1:0] HANDLE_SPEC_A   = 32'hFFFF_FF01;
	localparam logic [HANDLE_W-1:0] HANDLE_SPEC_B   = 32'hFFFF_FF03;
	localparam logic [HANDLE_W-1:0] HANDLE_SPEC_C   = 32'hFFFF_FF05;

	typedef enum logic [CMD_W-1:0] {
		CMD_ALLOC  = 2'd0,
		CMD_LOOKUP = 2'd1,
		CMD_FREE   = 2'd2
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK      = 2'd0,
		ST_INVALID = 2'd1,
		ST_NOMEM   = 2'd2
	} status_t;

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	// Strobes from the controller to the slot store
	typedef struct packed {
		logic rd_en;
		logic tag_we;
		logic link_we;
	} mem_ctl_t;

	function automatic logic is_reserved_handle(input logic [HANDLE_W-1:0] h);
		return (h == HANDLE_NULL) || (h == HANDLE_ALL_ONES) || (h == HANDLE_SPEC_A) ||
			(h == HANDLE_SPEC_B) || (h == HANDLE_SPEC_C);
	endfunction

endpackage

// ===== rtl/htfl_ifs.sv =====
// Request and response channel interfaces of the handle table.
interface htfl_req_if;
	logic                          valid;
	logic                          ready;
	logic [htfl_pkg::CMD_W-1:0]    cmd;
	logic [htfl_pkg::HANDLE_W-1:0] handle_in;
	logic [htfl_pkg::TAG_W-1:0]    object_tag_in;

	modport source(output valid, cmd, handle_in, object_tag_in, input ready);
	modport sink(input valid, cmd, handle_in, object_tag_in, output ready);
endinterface

interface htfl_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [htfl_pkg::STATUS_W-1:0] status;
	logic [htfl_pkg::HANDLE_W-1:0] handle_out;
	logic [htfl_pkg::TAG_W-1:0]    object_tag_out;

	modport source(output valid, status, handle_out, object_tag_out, input ready);
	modport sink(input valid, status, handle_out, object_tag_out, output ready);
endinterface

// ===== rtl/htfl_slot_store.sv =====
// Slot memories: tag plus allocated flag, and the free-list link per slot.
module htfl_slot_store #(
	parameter int DEPTH  = htfl_pkg::TABLE_DEPTH_DEF,
	parameter int IDX_W  = $clog2(htfl_pkg::TABLE_DEPTH_DEF),
	parameter int DATA_W = htfl_pkg::TAG_WIDTH_DEF
) (
	input  logic               clk,
	input  htfl_pkg::mem_ctl_t mem_ctl,
	input  logic [IDX_W-1:0]   tag_raddr,
	input  logic [IDX_W-1:0]   link_raddr,
	input  logic [IDX_W-1:0]   tag_waddr,
	input  logic [DATA_W-1:0]  tag_wdata,
	input  logic               tag_wused,
	input  logic [IDX_W-1:0]   link_waddr,
	input  logic [IDX_W-1:0]   link_wdata,
	output logic [DATA_W-1:0]  tag_rdata,
	output logic               used_rdata,
	output logic [IDX_W-1:0]   link_rdata
);

	logic [DATA_W:0]  slot_mem [DEPTH];
	logic [IDX_W-1:0] link_mem [DEPTH];
	logic [DATA_W:0]  slot_rd_q;
	logic [IDX_W-1:0] link_rd_q;

	// Slot word: allocated flag above the tag
	always_ff @(posedge clk) begin
		if (mem_ctl.tag_we)
			slot_mem[tag_waddr] <= {tag_wused, tag_wdata};
		if (mem_ctl.rd_en)
			slot_rd_q <= slot_mem[tag_raddr];
	end

	// Next-free links
	always_ff @(posedge clk) begin
		if (mem_ctl.link_we)
			link_mem[link_waddr] <= link_wdata;
		if (mem_ctl.rd_en)
			link_rd_q <= link_mem[link_raddr];
	end

	assign tag_rdata  = slot_rd_q[DATA_W-1:0];
	assign used_rdata = slot_rd_q[DATA_W];
	assign link_rdata = link_rd_q;

endmodule

// ===== rtl/htfl_ctrl.sv =====
// Request sequencer and free-list bookkeeping around the slot memories.
module htfl_ctrl #(
	parameter int TABLE_DEPTH = htfl_pkg::TABLE_DEPTH_DEF,
	parameter int GROW_CHUNK  = htfl_pkg::GROW_CHUNK_DEF,
	parameter int IDX_W       = $clog2(htfl_pkg::TABLE_DEPTH_DEF),
	parameter int STORE_W     = htfl_pkg::TAG_WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	htfl_req_if.sink           req,
	htfl_rsp_if.source         rsp,
	output htfl_pkg::mem_ctl_t mem_ctl,
	output logic [IDX_W-1:0]   tag_raddr,
	output logic [IDX_W-1:0]   link_raddr,
	output logic [IDX_W-1:0]   tag_waddr,
	output logic [STORE_W-1:0] tag_wdata,
	output logic               tag_wused,
	output logic [IDX_W-1:0]   link_waddr,
	output logic [IDX_W-1:0]   link_wdata,
	input  logic [STORE_W-1:0] tag_rdata,
	input  logic               used_rdata,
	input  logic [IDX_W-1:0]   link_rdata
);

	localparam int HW     = htfl_pkg::HANDLE_W;
	localparam int TPW    = htfl_pkg::TAG_W;
	localparam int SIZE_W = $clog2(TABLE_DEPTH + 1);
	localparam int GROW_W = $clog2(TABLE_DEPTH + GROW_CHUNK + 1);
	localparam int FIRST  = (GROW_CHUNK < TABLE_DEPTH) ? GROW_CHUNK : TABLE_DEPTH;

	// Control state
	htfl_pkg::state_t  state_q, state_d;
	logic [SIZE_W-1:0] fresh_q, fresh_d;    // first slot never handed out
	logic [SIZE_W-1:0] active_q, active_d;  // active table size
	logic [IDX_W-1:0]  head_q, head_d;      // head of the recycled chain
	logic [IDX_W-1:0]  tail_q, tail_d;      // tail of the recycled chain
	logic              list_valid_q, list_valid_d;
	logic              rsp_valid_q, rsp_valid_d;

	// Request held over the memory read
	htfl_pkg::cmd_t    cmd_s1;
	logic [STORE_W-1:0] tag_s1;
	logic [IDX_W-1:0]  idx_s1;
	logic              hit_s1;

	// Result register
	htfl_pkg::status_t status_q, status_d;
	logic [HW-1:0]     handle_q, handle_d;
	logic [TPW-1:0]    otag_q, otag_d;

	logic              accept;
	logic [HW-1:0]     dec_idx;
	logic              dec_hit;
	logic              fresh_avail;
	logic [GROW_W-1:0] grow_size;
	logic              can_grow;
	logic [IDX_W-1:0]  alloc_idx;
	logic              alloc_ok;
	logic              slot_hit;

	// Handshake: one request in flight, result register must be free by write-back
	assign req.ready = (state_q == htfl_pkg::S_IDLE) && (!rsp_valid_q || rsp.ready);
	assign accept    = req.valid && req.ready;

	// Handle decode: slot is (h >> 2) - 1, only slots handed out so far can hit
	assign dec_idx = {2'b00, req.handle_in[HW-1:2]} - HW'(1);
	assign dec_hit = !htfl_pkg::is_reserved_handle(req.handle_in) && (dec_idx < HW'(fresh_q));

	// Both memories are read on the accepting edge
	assign tag_raddr  = dec_idx[IDX_W-1:0];
	assign link_raddr = head_q;

	assign fresh_avail = fresh_q < active_q;
	assign grow_size   = GROW_W'(active_q) + GROW_W'(GROW_CHUNK);
	assign can_grow    = grow_size < GROW_W'(TABLE_DEPTH);
	assign slot_hit    = hit_s1 && used_rdata;

	// Next state, memory write-back and result
	always_comb begin
		state_d      = state_q;
		fresh_d      = fresh_q;
		active_d     = active_q;
		head_d       = head_q;
		tail_d       = tail_q;
		list_valid_d = list_valid_q;
		rsp_valid_d  = rsp_valid_q && !rsp.ready;
		status_d     = status_q;
		handle_d     = handle_q;
		otag_d       = otag_q;
		mem_ctl      = '{rd_en: accept, tag_we: 1'b0, link_we: 1'b0};
		tag_waddr    = idx_s1;
		tag_wdata    = tag_rdata;
		tag_wused    = 1'b0;
		link_waddr   = tail_q;
		link_wdata   = idx_s1;
		alloc_idx    = fresh_q[IDX_W-1:0];
		alloc_ok     = 1'b0;
		case (state_q)
			htfl_pkg::S_IDLE: begin
				if (accept)
					state_d = htfl_pkg::S_EXEC;
			end
			htfl_pkg::S_EXEC: begin
				state_d     = htfl_pkg::S_IDLE;
				rsp_valid_d = 1'b1;
				status_d    = htfl_pkg::ST_INVALID;
				handle_d    = '0;
				otag_d      = '0;
				case (cmd_s1)
					htfl_pkg::CMD_ALLOC: begin
						// Untouched slots first, then recycled ones, then a new chunk
						alloc_ok = 1'b1;
						if (fresh_avail) begin
							alloc_idx = fresh_q[IDX_W-1:0];
							fresh_d   = fresh_q + SIZE_W'(1);
						end else if (list_valid_q) begin
							alloc_idx = head_q;
							head_d    = link_rdata;
							if (head_q == tail_q)
								list_valid_d = 1'b0;
						end else if (can_grow) begin
							alloc_idx = active_q[IDX_W-1:0];
							active_d  = grow_size[SIZE_W-1:0];
							fresh_d   = active_q + SIZE_W'(1);
						end else begin
							alloc_ok = 1'b0;
							status_d = htfl_pkg::ST_NOMEM;
						end
						if (alloc_ok) begin
							mem_ctl.tag_we = 1'b1;
							tag_waddr      = alloc_idx;
							tag_wdata      = tag_s1;
							tag_wused      = 1'b1;
							status_d       = htfl_pkg::ST_OK;
							handle_d       = (HW'(alloc_idx) + HW'(1)) << 2;
						end
					end
					htfl_pkg::CMD_LOOKUP: begin
						if (slot_hit) begin
							status_d = htfl_pkg::ST_OK;
							otag_d   = TPW'(tag_rdata);
						end
					end
					htfl_pkg::CMD_FREE: begin
						// Clear the flag and append the slot behind the tail
						if (slot_hit) begin
							mem_ctl.tag_we = 1'b1;
							tag_wused      = 1'b0;
							if (list_valid_q)
								mem_ctl.link_we = 1'b1;
							else
								head_d = idx_s1;
							tail_d       = idx_s1;
							list_valid_d = 1'b1;
							status_d     = htfl_pkg::ST_OK;
						end
					end
					default: ;
				endcase
			end
			default: state_d = htfl_pkg::S_IDLE;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= htfl_pkg::S_IDLE;
			fresh_q      <= '0;
			active_q     <= SIZE_W'(FIRST);
			head_q       <= '0;
			tail_q       <= '0;
			list_valid_q <= 1'b0;
			rsp_valid_q  <= 1'b0;
		end else begin
			state_q      <= state_d;
			fresh_q      <= fresh_d;
			active_q     <= active_d;
			head_q       <= head_d;
			tail_q       <= tail_d;
			list_valid_q <= list_valid_d;
			rsp_valid_q  <= rsp_valid_d;
		end
	end

	// Request capture and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= htfl_pkg::cmd_t'(req.cmd);
			tag_s1 <= req.object_tag_in[STORE_W-1:0];
			idx_s1 <= dec_idx[IDX_W-1:0];
			hit_s1 <= dec_hit;
		end
		status_q <= status_d;
		handle_q <= handle_d;
		otag_q   <= otag_d;
	end

	assign rsp.valid          = rsp_valid_q;
	assign rsp.status         = status_q;
	assign rsp.handle_out     = handle_q;
	assign rsp.object_tag_out = otag_q;

endmodule

// ===== rtl/handle_table_free_list.sv =====
// Top level of the handle table with FIFO free list.
// On the accepting edge the slot memory and the link memory are read, and on
// the next edge the slot is updated, the free list registers move and the
// result is registered. One request is in flight at a time, and a new one is
// taken while the previous result still waits on the response channel only
// once that result is being transferred. Free slots come first from the
// untouched part of the active table in index order, then from the chain of
// freed slots, and a new chunk is opened when both are used up and the grown
// size stays below TABLE_DEPTH; opening a chunk needs no extra state, and no
// clearing pass runs after reset, since a slot that was never handed out is
// recognised by its index alone.
`include "handle_table_free_list_macros.svh"

module handle_table_free_list #(
	parameter int TABLE_DEPTH = htfl_pkg::TABLE_DEPTH_DEF,
	parameter int GROW_CHUNK  = htfl_pkg::GROW_CHUNK_DEF,
	parameter int TAG_WIDTH   = htfl_pkg::TAG_WIDTH_DEF
) (
	input logic        clk,
	input logic        arst_n,
	htfl_req_if.sink   req,
	htfl_rsp_if.source rsp
);

	localparam int IDX_W   = $clog2(TABLE_DEPTH);
	localparam int STORE_W = (TAG_WIDTH < htfl_pkg::TAG_W) ? TAG_WIDTH : htfl_pkg::TAG_W;

	htfl_pkg::mem_ctl_t mem_ctl;
	logic [IDX_W-1:0]   tag_raddr;
	logic [IDX_W-1:0]   link_raddr;
	logic [IDX_W-1:0]   tag_waddr;
	logic [STORE_W-1:0] tag_wdata;
	logic               tag_wused;
	logic [IDX_W-1:0]   link_waddr;
	logic [IDX_W-1:0]   link_wdata;
	logic [STORE_W-1:0] tag_rdata;
	logic               used_rdata;
	logic [IDX_W-1:0]   link_rdata;

	htfl_ctrl #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.GROW_CHUNK (GROW_CHUNK),
		.IDX_W      (IDX_W),
		.STORE_W    (STORE_W)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.mem_ctl   (mem_ctl),
		.tag_raddr (tag_raddr),
		.link_raddr(link_raddr),
		.tag_waddr (tag_waddr),
		.tag_wdata (tag_wdata),
		.tag_wused (tag_wused),
		.link_waddr(link_waddr),
		.link_wdata(link_wdata),
		.tag_rdata (tag_rdata),
		.used_rdata(used_rdata),
		.link_rdata(link_rdata)
	);

	htfl_slot_store #(
		.DEPTH (TABLE_DEPTH),
		.IDX_W (IDX_W),
		.DATA_W(STORE_W)
	) u_store (
		.clk       (clk),
		.mem_ctl   (mem_ctl),
		.tag_raddr (tag_raddr),
		.link_raddr(link_raddr),
		.tag_waddr (tag_waddr),
		.tag_wdata (tag_wdata),
		.tag_wused (tag_wused),
		.link_waddr(link_waddr),
		.link_wdata(link_wdata),
		.tag_rdata (tag_rdata),
		.used_rdata(used_rdata),
		.link_rdata(link_rdata)
	);

	// Checks
	`HTFL_ASSERT_NEXT(a_result_after_two, req.valid && req.ready, ##1 rsp.valid, "no result two cycles after a request transfer")
	`HTFL_ASSERT_NEXT(a_one_in_flight, req.valid && req.ready, !req.ready, "request taken while one is in flight")
	`HTFL_ASSERT(a_fail_fields_zero, rsp.valid && (rsp.status != htfl_pkg::ST_OK), (rsp.handle_out == '0) && (rsp.object_tag_out == '0), "failed request carries non-zero fields")

endmodule
